// ----- sv/csma_pkg.sv -----
// shared types, codes and reset values of the slotted csma/ca node mac
`default_nettype none
package csma_pkg;

  localparam int MAX_FRAME_SLOTS = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_BACKOFF = 3'd1;
  localparam logic [2:0] PH_CCA1    = 3'd2;
  localparam logic [2:0] PH_CCA2    = 3'd3;
  localparam logic [2:0] PH_SEND    = 3'd4;
  localparam logic [2:0] PH_COLL    = 3'd5;

  localparam logic [1:0] CMP_NONE         = 2'd0;
  localparam logic [1:0] CMP_SENT         = 2'd1;
  localparam logic [1:0] CMP_DROP_BACKOFF = 2'd2;
  localparam logic [1:0] CMP_DROP_RETRY   = 2'd3;

  localparam logic [2:0] REG_MIN_BE     = 3'd0;
  localparam logic [2:0] REG_MAX_BE     = 3'd1;
  localparam logic [2:0] REG_MAX_STAGES = 3'd2;
  localparam logic [2:0] REG_MAX_RETRY  = 3'd3;
  localparam logic [2:0] REG_WAKE       = 3'd4;
  localparam logic [2:0] REG_QUEUE_LIM  = 3'd5;
  localparam logic [2:0] REG_DATA       = 3'd6;
  localparam logic [2:0] REG_ACK        = 3'd7;

  localparam logic [3:0] RST_MIN_BE     = 4'd2;
  localparam logic [3:0] RST_MAX_BE     = 4'd8;
  localparam logic [2:0] RST_MAX_STAGES = 3'd5;
  localparam logic [2:0] RST_MAX_RETRY  = 3'd2;
  localparam logic [3:0] RST_WAKE       = 4'd1;
  localparam logic [3:0] RST_QUEUE_LIM  = 4'd5;
  localparam logic [4:0] RST_DATA       = 5'd6;
  localparam logic [3:0] RST_ACK        = 4'd1;

  typedef struct packed {
    logic [3:0] min_backoff_exp;
    logic [3:0] max_backoff_exp;
    logic [2:0] max_backoff_stages;
    logic [2:0] max_retries;
    logic [3:0] wake_slots;
    logic [3:0] queue_limit;
    logic [4:0] data_slots;
    logic [3:0] ack_slots;
  } cfg_t;

  typedef struct packed {
    logic [3:0] packet_count;
    logic [2:0] phase;
    logic [3:0] wake_count;
    logic [7:0] slot_count;
    logic [2:0] stage;
    logic [2:0] retry;
  } mac_state_t;

endpackage
`default_nettype wire

// ----- sv/csma_if.sv -----
// valid/ready channel interfaces for slot words and result words
`default_nettype none
interface csma_in_if;
  logic       valid;
  logic       ready;
  logic       packet_arrival;
  logic       active_slot;
  logic       channel_idle;
  logic       other_starts;
  logic [7:0] random_bits;

  modport source (output valid, packet_arrival, active_slot, channel_idle, other_starts,
                  random_bits, input ready);
  modport sink (input valid, packet_arrival, active_slot, channel_idle, other_starts,
                random_bits, output ready);
endinterface

interface csma_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] completion;
  logic       arrival_lost;
  logic [2:0] mac_phase;
  logic [3:0] queued_packets;
  logic       occupies_channel;
  logic [2:0] stage_now;
  logic [2:0] retry_now;

  modport source (output valid, completion, arrival_lost, mac_phase, queued_packets,
                  occupies_channel, stage_now, retry_now, input ready);
  modport sink (input valid, completion, arrival_lost, mac_phase, queued_packets,
                occupies_channel, stage_now, retry_now, output ready);
endinterface
`default_nettype wire

// ----- sv/slotted_csma_ca_node_mac.sv -----
// top level of the slotted csma/ca node mac: config, state, and result register
// Each input word is one backoff slot of the node. A word is taken in any cycle in
// which the result register is empty or its word is being taken, so the block runs
// at one slot per clock; the result word of a slot appears in the cycle after the slot
// word is accepted. The whole per-slot update (queue count, wake delay, backoff draw,
// cca, frame write into the FRAME_SLOTS-bit occupancy shift register) is one
// pass of logic from the state registers to the next state and result register.
// Configuration writes take effect at the next slot and belong in idle periods.
`default_nettype none
module slotted_csma_ca_node_mac #(
  parameter int FRAME_SLOTS = csma_pkg::MAX_FRAME_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  csma_in_if.sink                         in_ch,
  csma_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [csma_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [csma_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  csma_pkg::cfg_t         cfg_r;
  csma_pkg::mac_state_t   state_r;
  csma_pkg::mac_state_t   state_nxt;
  logic [FRAME_SLOTS-1:0] occ_r;
  logic [FRAME_SLOTS-1:0] occ_nxt;
  logic [1:0]             completion_nxt;
  logic                   lost_nxt;
  logic                   in_take;

  logic                   out_valid_r;
  logic [1:0]             completion_r;
  logic                   lost_r;
  logic [2:0]             phase_r;
  logic [3:0]             queued_r;
  logic                   occupies_r;
  logic [2:0]             stage_r;
  logic [2:0]             retry_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  csma_step #(
    .FRAME_SLOTS(FRAME_SLOTS)
  ) u_step (
    .cfg           (cfg_r),
    .state_cur     (state_r),
    .occ_cur       (occ_r),
    .packet_arrival(in_ch.packet_arrival),
    .active_slot   (in_ch.active_slot),
    .channel_idle  (in_ch.channel_idle),
    .other_starts  (in_ch.other_starts),
    .random_bits   (in_ch.random_bits),
    .state_nxt     (state_nxt),
    .occ_nxt       (occ_nxt),
    .completion    (completion_nxt),
    .arrival_lost  (lost_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_backoff_exp    <= csma_pkg::RST_MIN_BE;
      cfg_r.max_backoff_exp    <= csma_pkg::RST_MAX_BE;
      cfg_r.max_backoff_stages <= csma_pkg::RST_MAX_STAGES;
      cfg_r.max_retries        <= csma_pkg::RST_MAX_RETRY;
      cfg_r.wake_slots         <= csma_pkg::RST_WAKE;
      cfg_r.queue_limit        <= csma_pkg::RST_QUEUE_LIM;
      cfg_r.data_slots         <= csma_pkg::RST_DATA;
      cfg_r.ack_slots          <= csma_pkg::RST_ACK;
    end else if (cfg_we) begin
      case (cfg_idx)
        csma_pkg::REG_MIN_BE:     cfg_r.min_backoff_exp    <= cfg_wdata[3:0];
        csma_pkg::REG_MAX_BE:     cfg_r.max_backoff_exp    <= cfg_wdata[3:0];
        csma_pkg::REG_MAX_STAGES: cfg_r.max_backoff_stages <= cfg_wdata[2:0];
        csma_pkg::REG_MAX_RETRY:  cfg_r.max_retries        <= cfg_wdata[2:0];
        csma_pkg::REG_WAKE:       cfg_r.wake_slots         <= cfg_wdata[3:0];
        csma_pkg::REG_QUEUE_LIM:  cfg_r.queue_limit        <= cfg_wdata[3:0];
        csma_pkg::REG_DATA:       cfg_r.data_slots         <= cfg_wdata[4:0];
        csma_pkg::REG_ACK:        cfg_r.ack_slots          <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.packet_count <= 4'd0;
      state_r.phase        <= csma_pkg::PH_IDLE;
      state_r.wake_count   <= 4'd0;
      state_r.slot_count   <= 8'd0;
      state_r.stage        <= 3'd0;
      state_r.retry        <= 3'd0;
      occ_r                <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      completion_r <= completion_nxt;
      lost_r       <= lost_nxt;
      phase_r      <= state_nxt.phase;
      queued_r     <= state_nxt.packet_count;
      occupies_r   <= occ_nxt[0];
      stage_r      <= state_nxt.stage;
      retry_r      <= state_nxt.retry;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.completion       = completion_r;
  assign out_ch.arrival_lost     = lost_r;
  assign out_ch.mac_phase        = phase_r;
  assign out_ch.queued_packets   = queued_r;
  assign out_ch.occupies_channel = occupies_r;
  assign out_ch.stage_now        = stage_r;
  assign out_ch.retry_now        = retry_r;

  a_take_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid_r)
    else $error("accepted slot word did not load the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("slot word accepted while result word stalled");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == csma_pkg::PH_IDLE) |-> (state_r.stage == 3'd0 && state_r.retry == 3'd0))
    else $error("idle phase with nonzero stage or retry");

  a_empty_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && completion_r != csma_pkg::CMP_NONE && queued_r == 4'd0)
      |-> (phase_r == csma_pkg::PH_IDLE))
    else $error("finished last packet but not idle");

endmodule
`default_nettype wire

// ----- sv/csma_step.sv -----
// per-slot next-state logic of the mac: queue, backoff, cca, frame and occupancy
`default_nettype none
module csma_step #(
  parameter int FRAME_SLOTS = csma_pkg::MAX_FRAME_SLOTS
) (
  input  csma_pkg::cfg_t       cfg,
  input  csma_pkg::mac_state_t state_cur,
  input  logic [FRAME_SLOTS-1:0] occ_cur,
  input  logic                 packet_arrival,
  input  logic                 active_slot,
  input  logic                 channel_idle,
  input  logic                 other_starts,
  input  logic [7:0]           random_bits,
  output csma_pkg::mac_state_t state_nxt,
  output logic [FRAME_SLOTS-1:0] occ_nxt,
  output logic [1:0]           completion,
  output logic                 arrival_lost
);

  function automatic csma_pkg::mac_state_t draw(csma_pkg::mac_state_t s,
                                                csma_pkg::cfg_t c, logic [7:0] rnd);
    logic [4:0] be;
    logic [7:0] mask;
    be = 5'(c.min_backoff_exp) + 5'(s.stage);
    if (be > {1'b0, c.max_backoff_exp}) be = {1'b0, c.max_backoff_exp};
    if (be > 5'd8) be = 5'd8;
    mask = 8'((9'd1 << be[3:0]) - 9'd1);
    s.slot_count = rnd & mask;
    s.phase = (s.slot_count != 8'd0) ? csma_pkg::PH_BACKOFF : csma_pkg::PH_CCA1;
    return s;
  endfunction

  function automatic csma_pkg::mac_state_t start_access(csma_pkg::mac_state_t s,
                                                        csma_pkg::cfg_t c, logic [7:0] rnd);
    s.stage = 3'd0;
    s.retry = 3'd0;
    return draw(s, c, rnd);
  endfunction

  function automatic csma_pkg::mac_state_t finish(csma_pkg::mac_state_t s,
                                                  csma_pkg::cfg_t c, logic [7:0] rnd);
    if (s.packet_count != 4'd0) s.packet_count = s.packet_count - 4'd1;
    if (s.packet_count != 4'd0) begin
      s = start_access(s, c, rnd);
    end else begin
      s.phase      = csma_pkg::PH_IDLE;
      s.wake_count = 4'd0;
      s.stage      = 3'd0;
      s.retry      = 3'd0;
      s.slot_count = 8'd0;
    end
    return s;
  endfunction

  logic                   busy;
  logic                   start_frame;
  logic [3:0]             ws;
  logic [6:0]             last;
  logic [FRAME_SLOTS-1:0] occ_w;

  assign busy = !channel_idle || occ_cur[0];
  assign ws   = (cfg.wake_slots == 4'd0) ? 4'd1 : cfg.wake_slots;
  assign last = 7'(cfg.data_slots) + 7'(cfg.ack_slots) + 7'd1;

  always_comb begin
    state_nxt    = state_cur;
    completion   = csma_pkg::CMP_NONE;
    arrival_lost = 1'b0;
    start_frame  = 1'b0;
    occ_w        = occ_cur;
    occ_nxt      = occ_cur;

    if (packet_arrival) begin
      if (state_nxt.packet_count < cfg.queue_limit) begin
        state_nxt.packet_count = state_nxt.packet_count + 4'd1;
      end else begin
        arrival_lost = 1'b1;
      end
    end

    if (active_slot) begin
      case (state_cur.phase)
        csma_pkg::PH_BACKOFF: begin
          if (state_nxt.slot_count != 8'd0) state_nxt.slot_count = state_nxt.slot_count - 8'd1;
          if (state_nxt.slot_count == 8'd0) state_nxt.phase = csma_pkg::PH_CCA1;
        end
        csma_pkg::PH_CCA1, csma_pkg::PH_CCA2: begin
          if (!busy) begin
            if (state_cur.phase == csma_pkg::PH_CCA1) begin
              state_nxt.phase = csma_pkg::PH_CCA2;
            end else begin
              start_frame = 1'b1;
            end
          end else if (state_nxt.stage < cfg.max_backoff_stages) begin
            state_nxt.stage = state_nxt.stage + 3'd1;
            state_nxt = draw(state_nxt, cfg, random_bits);
          end else begin
            state_nxt  = finish(state_nxt, cfg, random_bits);
            completion = csma_pkg::CMP_DROP_BACKOFF;
          end
        end
        csma_pkg::PH_SEND: begin
          if (state_nxt.slot_count > 8'd1) begin
            state_nxt.slot_count = state_nxt.slot_count - 8'd1;
          end else begin
            state_nxt  = finish(state_nxt, cfg, random_bits);
            completion = csma_pkg::CMP_SENT;
          end
        end
        csma_pkg::PH_COLL: begin
          if (state_nxt.slot_count > 8'd1) begin
            state_nxt.slot_count = state_nxt.slot_count - 8'd1;
          end else if (state_nxt.retry < cfg.max_retries) begin
            state_nxt.retry = state_nxt.retry + 3'd1;
            state_nxt.stage = 3'd0;
            state_nxt = draw(state_nxt, cfg, random_bits);
          end else begin
            state_nxt  = finish(state_nxt, cfg, random_bits);
            completion = csma_pkg::CMP_DROP_RETRY;
          end
        end
        default: begin
          state_nxt.phase      = csma_pkg::PH_IDLE;
          state_nxt.wake_count = state_nxt.wake_count + 4'd1;
          if (state_nxt.wake_count >= ws) begin
            state_nxt.wake_count = 4'd0;
            if (state_nxt.packet_count != 4'd0) begin
              state_nxt = start_access(state_nxt, cfg, random_bits);
            end
          end
        end
      endcase

      if (start_frame) begin
        state_nxt.phase      = other_starts ? csma_pkg::PH_COLL : csma_pkg::PH_SEND;
        state_nxt.slot_count = 8'(last);
        // data slots set, one gap slot, then ack window only on success
        for (int p = 1; p < FRAME_SLOTS; p++) begin
          if (7'(p) <= last) begin
            if (7'(p) <= 7'(cfg.data_slots)) begin
              occ_w[p] = 1'b1;
            end else if (7'(p) == 7'(cfg.data_slots) + 7'd1) begin
              occ_w[p] = 1'b0;
            end else begin
              occ_w[p] = !other_starts;
            end
          end
        end
      end
      occ_nxt = occ_w >> 1;
    end
  end

endmodule
`default_nettype wire
